// ===== hw/rtl/chrl_pkg.sv =====
// Package for the consistent-hash ring lookup block.
// Holds payload structs, op and status codes, FNV-1a constants and the state enum.
// No dependencies.
package chrl_pkg;

   localparam logic [31:0] HASH_BASIS = 32'd2166136261;
   localparam logic [31:0] HASH_PRIME = 32'd16777619;
   localparam logic [7:0]  CHAR_HASH  = 8'h23;
   localparam logic [7:0]  CHAR_ZERO  = 8'h30;

   typedef enum logic [1:0] {
      OP_KEY    = 2'd0,
      OP_SERVER = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_EMPTY      = 2'd1,
      ST_TOO_MANY   = 2'd2,
      ST_RING_FULL  = 2'd3
   } status_type;

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_ACK    = 1'b1;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic       result_kind;
      logic [3:0] server_index;
      logic [1:0] status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_VN_START,
      S_VN_DIGIT,
      S_INS_READ,
      S_INS_WAIT,
      S_INS_CMP,
      S_INS_PUT,
      S_LK_READ,
      S_LK_WAIT,
      S_LK_CMP,
      S_LK_OWN,
      S_LK_OWNW,
      S_RESP
   } state_type;

   function automatic logic [31:0] mix_byte(input logic [31:0] h, input logic [7:0] b);
      logic [31:0] x;
      x = h ^ {24'd0, b};
      return x * HASH_PRIME;
   endfunction

endpackage

// ===== hw/rtl/chrl_ring_mem.sv =====
// Ring table memory: sorted hashes and owners, one write and one read port.
// Depends on nothing outside this file.
module chrl_ring_mem #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_hash,
   input  logic [3:0]    wr_owner,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_hash,
   output logic [3:0]    rd_owner
);

   logic [31:0] hash_mem [DEPTH];
   logic [3:0]  owner_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hash_mem[wr_addr]  <= wr_hash;
         owner_mem[wr_addr] <= wr_owner;
      end
      rd_hash  <= hash_mem[rd_addr];
      rd_owner <= owner_mem[rd_addr];
   end

endmodule

// ===== hw/rtl/consistent_hash_ring_lookup_top.sv =====
// Consistent-hash ring lookup top level: FNV-1a hashing, sorted ring insert and search.
// A byte that is not last only folds into the running name hash; an error ack or an empty lookup
// goes straight to the response. A server's last byte hashes each virtual node and inserts it in
// sorted order; a lookup scans the ring for the first entry at or above the key hash.
// One transaction at a time; the next waits until the result is taken. Reset empties the ring.
// Depends on chrl_pkg and chrl_ring_mem.
module consistent_hash_ring_lookup_top #(
   parameter int MAX_SERVERS       = 16,
   parameter int VNODES_PER_SERVER = 16,
   parameter int RING_DEPTH        = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  chrl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output chrl_pkg::rsp_type rsp_data
);

   localparam int AW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CW  = $clog2(RING_DEPTH + 1);
   localparam int SW  = $clog2(MAX_SERVERS + 1);
   localparam int VW  = $clog2(VNODES_PER_SERVER + 1);
   localparam logic [CW:0] VN_C = (CW+1)'(VNODES_PER_SERVER);
   localparam logic [CW:0] RD_C = (CW+1)'(RING_DEPTH);

   chrl_pkg::state_type state_ff, state_in;

   logic [31:0]   hash_ff, hash_in;
   logic [31:0]   name_ff, name_in;
   logic [31:0]   vh_ff, vh_in;
   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] servers_ff, servers_in;
   logic          failed_ff, failed_in;
   logic [VW-1:0] vn_ff, vn_in;
   logic [15:0]   digits_ff, digits_in;
   logic [2:0]    ndig_ff, ndig_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [3:0]    owner_ff, owner_in;
   chrl_pkg::rsp_type rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0]   wr_hash, rd_hash;
   logic [3:0]    wr_owner, rd_owner;

   chrl_ring_mem #(.DEPTH(RING_DEPTH), .AW(AW)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_hash(wr_hash),
      .wr_owner(wr_owner), .rd_addr(rd_addr), .rd_hash(rd_hash), .rd_owner(rd_owner)
   );

   logic req_fire;
   assign req_ready = (state_ff == chrl_pkg::S_IDLE) && !rsp_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // decimal digits of the virtual-node number, packed BCD
   function automatic logic [15:0] to_bcd(input logic [VW-1:0] v);
      logic [15:0] b;
      b = '0;
      for (int i = VW - 1; i >= 0; i--) begin
         for (int d = 0; d < 4; d++) begin
            if (b[d*4 +: 4] >= 4'd5) b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
         end
         b = {b[14:0], v[i]};
      end
      return b;
   endfunction

   logic [15:0] vn_bcd;
   logic [2:0]  vn_ndig;
   assign vn_bcd  = to_bcd(vn_ff);
   assign vn_ndig = (vn_bcd[15:12] != 4'd0) ? 3'd4 :
                    (vn_bcd[11:8]  != 4'd0) ? 3'd3 :
                    (vn_bcd[7:4]   != 4'd0) ? 3'd2 : 3'd1;

   logic [7:0] mix_b;
   logic [31:0] mix_h, mix_out;
   assign mix_out = chrl_pkg::mix_byte(mix_h, mix_b);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         chrl_pkg::S_IDLE: begin
            if (req_fire && req_data.last) begin
               if (req_data.op == chrl_pkg::OP_SERVER) begin
                  if ({1'b0, servers_ff} >= (SW+1)'(MAX_SERVERS)) state_in = chrl_pkg::S_RESP;
                  else if (VN_C > RD_C - {1'b0, count_ff}) state_in = chrl_pkg::S_RESP;
                  else state_in = chrl_pkg::S_VN_START;
               end else if (req_data.op == chrl_pkg::OP_KEY) begin
                  if (failed_ff || count_ff == '0) state_in = chrl_pkg::S_RESP;
                  else state_in = chrl_pkg::S_LK_READ;
               end
            end
         end
         chrl_pkg::S_VN_START: state_in = chrl_pkg::S_VN_DIGIT;
         chrl_pkg::S_VN_DIGIT: if (ndig_ff == 3'd1) state_in = chrl_pkg::S_INS_READ;
         chrl_pkg::S_INS_READ: begin
            if (pos_ff == '0) state_in = chrl_pkg::S_INS_PUT;
            else state_in = chrl_pkg::S_INS_WAIT;
         end
         chrl_pkg::S_INS_WAIT: state_in = chrl_pkg::S_INS_CMP;
         chrl_pkg::S_INS_CMP: begin
            if (rd_hash > vh_ff) state_in = chrl_pkg::S_INS_READ;
            else state_in = chrl_pkg::S_INS_PUT;
         end
         chrl_pkg::S_INS_PUT: begin
            if ({1'b0, vn_ff} == (VW+1)'(VNODES_PER_SERVER - 1)) state_in = chrl_pkg::S_RESP;
            else state_in = chrl_pkg::S_VN_START;
         end
         chrl_pkg::S_LK_READ: state_in = chrl_pkg::S_LK_WAIT;
         chrl_pkg::S_LK_WAIT: state_in = chrl_pkg::S_LK_CMP;
         chrl_pkg::S_LK_CMP: begin
            if (name_ff <= rd_hash) state_in = chrl_pkg::S_LK_OWN;
            else if (pos_ff + 1'b1 == count_ff) state_in = chrl_pkg::S_LK_OWN;
            else state_in = chrl_pkg::S_LK_READ;
         end
         chrl_pkg::S_LK_OWN:  state_in = chrl_pkg::S_LK_OWNW;
         chrl_pkg::S_LK_OWNW: state_in = chrl_pkg::S_RESP;
         chrl_pkg::S_RESP:    state_in = chrl_pkg::S_IDLE;
         default:             state_in = chrl_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      hash_in = hash_ff;
      name_in = name_ff;
      vh_in = vh_ff;
      count_in = count_ff;
      servers_in = servers_ff;
      failed_in = failed_ff;
      vn_in = vn_ff;
      digits_in = digits_ff;
      ndig_in = ndig_ff;
      pos_in = pos_ff;
      owner_in = owner_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en = 1'b0;
      wr_addr = pos_ff[AW-1:0];
      wr_hash = rd_hash;
      wr_owner = rd_owner;
      rd_addr = pos_ff[AW-1:0];
      mix_h = vh_ff;
      mix_b = chrl_pkg::CHAR_HASH;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         chrl_pkg::S_IDLE: begin
            mix_h = hash_ff;
            mix_b = req_data.data_byte;
            if (req_fire) begin
               if (req_data.op == chrl_pkg::OP_CLEAR) begin
                  count_in = '0;
                  servers_in = '0;
                  failed_in = 1'b0;
                  hash_in = chrl_pkg::HASH_BASIS;
               end else if (req_data.op != chrl_pkg::OP_NONE) begin
                  hash_in = mix_out;
                  if (req_data.last) begin
                     hash_in = chrl_pkg::HASH_BASIS;
                     name_in = mix_out;
                     vn_in = '0;
                     owner_in = servers_ff[3:0];
                     pos_in = '0;
                     rsp_in.result_kind = (req_data.op == chrl_pkg::OP_SERVER) ?
                                          chrl_pkg::KIND_ACK : chrl_pkg::KIND_LOOKUP;
                     rsp_in.server_index = '0;
                     rsp_in.status = chrl_pkg::ST_OK;
                     if (req_data.op == chrl_pkg::OP_SERVER) begin
                        if ({1'b0, servers_ff} >= (SW+1)'(MAX_SERVERS)) begin
                           rsp_in.status = chrl_pkg::ST_TOO_MANY;
                           failed_in = 1'b1;
                        end else if (VN_C > RD_C - {1'b0, count_ff}) begin
                           rsp_in.status = chrl_pkg::ST_RING_FULL;
                           failed_in = 1'b1;
                        end else begin
                           rsp_in.server_index = servers_ff[3:0];
                        end
                     end else if (failed_ff || count_ff == '0) begin
                        rsp_in.status = chrl_pkg::ST_EMPTY;
                     end
                  end
               end
            end
         end
         chrl_pkg::S_VN_START: begin
            mix_h = name_ff;
            mix_b = chrl_pkg::CHAR_HASH;
            vh_in = mix_out;
            digits_in = vn_bcd;
            ndig_in = vn_ndig;
         end
         chrl_pkg::S_VN_DIGIT: begin
            mix_h = vh_ff;
            mix_b = chrl_pkg::CHAR_ZERO | {4'd0, digits_ff[({1'b0, ndig_ff} - 4'd1) * 4 +: 4]};
            vh_in = mix_out;
            ndig_in = ndig_ff - 3'd1;
            pos_in = count_ff;
         end
         chrl_pkg::S_INS_READ: begin
            rd_addr = AW'(pos_ff - 1'b1);
         end
         chrl_pkg::S_INS_WAIT: begin
            rd_addr = AW'(pos_ff - 1'b1);
         end
         chrl_pkg::S_INS_CMP: begin
            if (rd_hash > vh_ff) begin
               wr_en = 1'b1;
               wr_addr = pos_ff[AW-1:0];
               pos_in = pos_ff - 1'b1;
            end
         end
         chrl_pkg::S_INS_PUT: begin
            wr_en = 1'b1;
            wr_addr = pos_ff[AW-1:0];
            wr_hash = vh_ff;
            wr_owner = owner_ff;
            count_in = count_ff + 1'b1;
            vn_in = vn_ff + 1'b1;
            if ({1'b0, vn_ff} == (VW+1)'(VNODES_PER_SERVER - 1))
               servers_in = servers_ff + 1'b1;
         end
         chrl_pkg::S_LK_CMP: begin
            if (name_ff <= rd_hash) begin
               pos_in = pos_ff;
            end else if (pos_ff + 1'b1 == count_ff) begin
               pos_in = '0;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         chrl_pkg::S_LK_OWNW: begin
            rsp_in.server_index = rd_owner;
         end
         chrl_pkg::S_RESP: begin
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= chrl_pkg::S_IDLE;
         hash_ff <= chrl_pkg::HASH_BASIS;
         count_ff <= '0;
         servers_ff <= '0;
         failed_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hash_ff <= hash_in;
         count_ff <= count_in;
         servers_ff <= servers_in;
         failed_ff <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      name_ff <= name_in;
      vh_ff <= vh_in;
      vn_ff <= vn_in;
      digits_ff <= digits_in;
      ndig_ff <= ndig_in;
      pos_ff <= pos_in;
      owner_ff <= owner_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ===== dv/chrl_checker.sv =====
// Checker for the consistent-hash ring lookup block: watches both channels,
// predicts every result from accepted requests and compares field by field.
// Depends on chrl_pkg.
module chrl_checker #(
   parameter int MAX_SERVERS       = 16,
   parameter int VNODES_PER_SERVER = 16,
   parameter int RING_DEPTH        = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  chrl_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  chrl_pkg::rsp_type rsp_data,
   output int                errors,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [31:0] name_hash;
   logic [31:0] ring_hash [RING_DEPTH];
   logic [3:0]  ring_owner [RING_DEPTH];
   int          ring_len;
   int          server_cnt;
   bit          build_bad;
   chrl_pkg::rsp_type expected_q[$];

   function automatic logic [31:0] fnv_fold(logic [31:0] h, logic [7:0] b);
      logic [31:0] t;
      t = h ^ {24'd0, b};
      return t * chrl_pkg::HASH_PRIME;
   endfunction

   function automatic logic [31:0] vnode_point(logic [31:0] h, int v);
      logic [7:0] digit [4];
      int         n;
      n = 0;
      h = fnv_fold(h, chrl_pkg::CHAR_HASH);
      do begin
         digit[n] = chrl_pkg::CHAR_ZERO + 8'(v % 10);
         v = v / 10;
         n++;
      end while (v != 0 && n < 4);
      while (n > 0) begin
         n--;
         h = fnv_fold(h, digit[n]);
      end
      return h;
   endfunction

   task automatic place_point(logic [31:0] h, logic [3:0] owner);
      int pos;
      pos = ring_len;
      while (pos > 0 && ring_hash[pos-1] > h) begin
         ring_hash[pos]  = ring_hash[pos-1];
         ring_owner[pos] = ring_owner[pos-1];
         pos--;
      end
      ring_hash[pos]  = h;
      ring_owner[pos] = owner;
      ring_len++;
   endtask

   task automatic predict_owner(chrl_pkg::req_type r);
      chrl_pkg::rsp_type res;
      logic [31:0]       h;
      int                pick;
      if (r.op == chrl_pkg::OP_CLEAR) begin
         ring_len   = 0;
         server_cnt = 0;
         build_bad  = 0;
         name_hash  = chrl_pkg::HASH_BASIS;
         return;
      end
      if (r.op == chrl_pkg::OP_NONE) return;
      name_hash = fnv_fold(name_hash, r.data_byte);
      if (!r.last) return;
      h         = name_hash;
      name_hash = chrl_pkg::HASH_BASIS;
      res       = '0;
      if (r.op == chrl_pkg::OP_SERVER) begin
         res.result_kind = chrl_pkg::KIND_ACK;
         if (server_cnt >= MAX_SERVERS) begin
            res.status = chrl_pkg::ST_TOO_MANY;
            build_bad  = 1;
         end else if (VNODES_PER_SERVER > RING_DEPTH - ring_len) begin
            res.status = chrl_pkg::ST_RING_FULL;
            build_bad  = 1;
         end else begin
            res.server_index = 4'(server_cnt);
            for (int v = 0; v < VNODES_PER_SERVER; v++)
               place_point(vnode_point(h, v), 4'(server_cnt));
            server_cnt++;
         end
      end else begin
         res.result_kind = chrl_pkg::KIND_LOOKUP;
         if (build_bad || ring_len == 0) begin
            res.status = chrl_pkg::ST_EMPTY;
         end else begin
            pick = 0;
            for (int i = 0; i < ring_len; i++) begin
               if (h <= ring_hash[i]) begin
                  pick = i;
                  break;
               end
            end
            res.server_index = ring_owner[pick];
         end
      end
      expected_q.push_back(res);
   endtask

   always @(posedge clock) begin
      chrl_pkg::rsp_type want;
      if (reset) begin
         name_hash  = chrl_pkg::HASH_BASIS;
         ring_len   = 0;
         server_cnt = 0;
         build_bad  = 0;
         expected_q.delete();
         errors     <= 0;
         pending    <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected transaction, actual %p", $time, rsp_data);
               errors <= errors + 1;
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.result_kind !== want.result_kind ||
                   rsp_data.server_index !== want.server_index ||
                   rsp_data.status !== want.status) begin
                  $display("%0t: mismatch, expected %p, actual %p", $time, want, rsp_data);
                  errors <= errors + 1;
               end
            end
         end
         if (req_valid && req_ready) predict_owner(req_data);
         pending <= expected_q.size();
      end
   end
endmodule

// ===== dv/tb.sv =====
// Top testbench for consistent_hash_ring_lookup_top: drives server builds,
// key lookups, clears and noise with random idling and back-pressure.
// Depends on chrl_pkg, chrl_checker and the block's RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 80000;
   localparam int ITEM_TARGET    = 1650;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   chrl_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   chrl_pkg::rsp_type rsp_data;
   int                errors;
   int                pending;
   int                item_cnt;
   int                quiet_cycles;
   bit                tx_idle;
   bit                rx_idle;

   consistent_hash_ring_lookup_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   chrl_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .errors    (errors),
      .pending   (pending)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int gap;
      int taken;
      rsp_ready = 1'b0;
      rx_idle   = 1'b1;
      taken     = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = rx_idle ? $urandom_range(0, 3) : 0;
         if (taken == 60) gap = 600;
         if (taken % 150 == 149) rx_idle = $urandom_range(0, 1);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   task automatic send_item(chrl_pkg::op_type op, logic [7:0] b, logic last);
      int gap;
      gap = tx_idle ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data.op    <= op;
      req_data.data_byte <= b;
      req_data.last  <= last;
      do @(posedge clock); while (!req_ready);
      item_cnt++;
   endtask

   task automatic send_string(chrl_pkg::op_type op, int len);
      for (int i = 1; i <= len; i++)
         send_item(op, 8'($urandom), i == len);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic add_servers(int n);
      for (int s = 0; s < n; s++) send_string(chrl_pkg::OP_SERVER, $urandom_range(1, 6));
   endtask

   initial begin
      int servers;
      int keys;
      req_valid = 1'b0;
      req_data  = '0;
      reset     = 1'b1;
      item_cnt  = 0;
      tx_idle   = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_item(chrl_pkg::OP_KEY, 8'h00, 1'b1);
      send_item(chrl_pkg::OP_KEY, 8'hFF, 1'b0);
      send_item(chrl_pkg::OP_KEY, 8'h00, 1'b1);
      send_item(chrl_pkg::OP_SERVER, 8'hFF, 1'b1);
      send_item(chrl_pkg::OP_SERVER, 8'h00, 1'b1);
      send_item(chrl_pkg::OP_KEY, 8'h00, 1'b1);
      send_item(chrl_pkg::OP_KEY, 8'hFF, 1'b1);
      send_item(chrl_pkg::OP_NONE, 8'hA5, 1'b1);
      send_item(chrl_pkg::OP_KEY, 8'h5A, 1'b0);
      send_item(chrl_pkg::OP_SERVER, 8'h3C, 1'b1);
      send_item(chrl_pkg::OP_SERVER, 8'h11, 1'b0);
      send_item(chrl_pkg::OP_KEY, 8'h22, 1'b1);
      send_item(chrl_pkg::OP_KEY, 8'h33, 1'b0);
      send_item(chrl_pkg::OP_CLEAR, 8'h00, 1'b0);
      send_item(chrl_pkg::OP_KEY, 8'h44, 1'b1);
      drain_results();
      add_servers(17);
      send_item(chrl_pkg::OP_KEY, 8'hFF, 1'b1);
      send_item(chrl_pkg::OP_KEY, 8'h00, 1'b1);
      send_item(chrl_pkg::OP_CLEAR, 8'hFF, 1'b1);
      send_item(chrl_pkg::OP_KEY, 8'h80, 1'b1);

      while (item_cnt < ITEM_TARGET) begin
         drain_results();
         tx_idle = $urandom_range(0, 3) != 0;
         send_item(chrl_pkg::OP_CLEAR, 8'($urandom), 1'($urandom));
         case ($urandom_range(0, 19))
            0:       servers = 17;
            1:       servers = 16;
            2:       servers = 0;
            default: servers = $urandom_range(1, 5);
         endcase
         add_servers(servers);
         keys = (servers >= 16) ? $urandom_range(4, 10) : $urandom_range(10, 40);
         for (int k = 0; k < keys; k++) begin
            case ($urandom_range(0, 19))
               0:       send_item(chrl_pkg::OP_NONE, 8'($urandom), 1'($urandom));
               1:       send_item(chrl_pkg::op_type'($urandom_range(0, 1)), 8'($urandom), 1'b0);
               2:       send_string(chrl_pkg::OP_SERVER, $urandom_range(1, 3));
               default: send_string(chrl_pkg::OP_KEY, $urandom_range(1, 8));
            endcase
         end
      end
      drain_results();
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
